// ===== hdl/ipv4fb_pkg.sv =====
package ipv4fb_pkg;

    // field widths
    localparam int ADDR_W  = 32;
    localparam int MAC_W   = 48;
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 11;
    localparam int TOTAL_W = 12;
    localparam int SUM_W   = 20;

    // frame layout
    localparam int HDR_BYTES    = 34;
    localparam int IP_HDR_BYTES = 20;
    localparam int IDX_W        = $clog2(HDR_BYTES);
    localparam int MAX_PAYLOAD  = 1480;

    // default depth of the queue between front and back
    localparam int FIFO_DEPTH_DEFAULT = 4;

    // header constants
    localparam logic [7:0]  ETHERTYPE_HI = 8'h08;
    localparam logic [7:0]  ETHERTYPE_LO = 8'h00;
    localparam logic [7:0]  VER_IHL      = 8'h45;
    localparam logic [7:0]  TTL_DEFAULT  = 8'd64;
    localparam logic [7:0]  FLAGS_DF     = 8'h40;
    localparam logic [15:0] IP_ID        = 16'h0001;
    // fixed words of the IPv4 header folded into one checksum start value
    localparam logic [15:0] CSUM_BASE    = {VER_IHL, 8'h00} + IP_ID + {FLAGS_DF, 8'h00};

    // configuration register indexes and reset values
    localparam logic CFG_IDX_W = 1'b1;
    localparam logic REG_DEST_MAC   = 1'b0;
    localparam logic REG_SOURCE_MAC = 1'b1;
    localparam logic [MAC_W-1:0] DEST_MAC_RESET   = 48'hFFFF_FFFF_FFFF;
    localparam logic [MAC_W-1:0] SOURCE_MAC_RESET = 48'h0200_0000_0001;

    // input command codes
    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_PAYLOAD = 1'b1;

    typedef enum logic [1:0] {
        KIND_HEADER,
        KIND_PAYLOAD,
        KIND_ERROR
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] data;
        logic              last;
        logic [ADDR_W-1:0] dest_addr;
        logic [ADDR_W-1:0] source_addr;
        logic [BYTE_W-1:0] proto_number;
        logic [LEN_W-1:0]  payload_length;
    } entry_t;

    typedef struct packed {
        logic [MAC_W-1:0] dest_mac;
        logic [MAC_W-1:0] source_mac;
    } mac_cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ===== hdl/ipv4fb_if.sv =====
interface ipv4fb_item_if;
    logic                            valid;
    logic                            ready;
    logic                            command;
    logic [ipv4fb_pkg::ADDR_W-1:0]   dest_addr;
    logic [ipv4fb_pkg::ADDR_W-1:0]   source_addr;
    logic [ipv4fb_pkg::BYTE_W-1:0]   proto_number;
    logic [ipv4fb_pkg::LEN_W-1:0]    payload_length;
    logic [ipv4fb_pkg::BYTE_W-1:0]   payload_byte;

    modport source (
        output valid, command, dest_addr, source_addr, proto_number,
               payload_length, payload_byte,
        input  ready
    );
    modport sink (
        input  valid, command, dest_addr, source_addr, proto_number,
               payload_length, payload_byte,
        output ready
    );
endinterface

interface ipv4fb_result_if;
    logic                          valid;
    logic                          ready;
    logic [ipv4fb_pkg::BYTE_W-1:0] frame_byte;
    logic                          frame_end;
    logic                          error;

    modport source (output valid, frame_byte, frame_end, error, input ready);
    modport sink (input valid, frame_byte, frame_end, error, output ready);
endinterface

interface ipv4fb_cfg_if;
    logic                         valid;
    logic                         ready;
    logic                         index;
    logic [ipv4fb_pkg::MAC_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/ipv4fb_front.sv =====
module ipv4fb_front (
    input  logic                   clk,
    input  logic                   rst_n,
    ipv4fb_item_if.sink            item_in,
    input  ipv4fb_pkg::q_status_t  q_status,
    output logic                   q_push,
    output ipv4fb_pkg::entry_t     q_entry
);
    import ipv4fb_pkg::*;

    logic             in_payload_reg;
    logic             in_payload_next;
    logic [LEN_W-1:0] bytes_left_reg;
    logic [LEN_W-1:0] bytes_left_next;
    logic [LEN_W-1:0] bytes_dec;
    logic             too_long;

    // accept whenever the queue has room
    assign item_in.ready = !q_status.full;
    assign q_push        = item_in.valid && !q_status.full;

    assign bytes_dec = bytes_left_reg - 1'b1;
    assign too_long  = int'(item_in.payload_length) > MAX_PAYLOAD;

    // classify the item and track the frame in progress
    always_comb
    begin
        in_payload_next        = in_payload_reg;
        bytes_left_next        = bytes_left_reg;
        q_entry                = '0;
        q_entry.dest_addr      = item_in.dest_addr;
        q_entry.source_addr    = item_in.source_addr;
        q_entry.proto_number   = item_in.proto_number;
        q_entry.payload_length = item_in.payload_length;
        q_entry.kind           = KIND_ERROR;
        if (item_in.command == CMD_PAYLOAD)
        begin
            if (in_payload_reg)
            begin
                q_entry.kind    = KIND_PAYLOAD;
                q_entry.data    = item_in.payload_byte;
                q_entry.last    = (bytes_dec == '0);
                bytes_left_next = bytes_dec;
                in_payload_next = (bytes_dec != '0);
            end
        end
        else if (too_long)
        begin
            in_payload_next = 1'b0;
            bytes_left_next = '0;
        end
        else
        begin
            q_entry.kind    = KIND_HEADER;
            in_payload_next = (item_in.payload_length != '0);
            bytes_left_next = item_in.payload_length;
        end
    end

    // hold frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_payload_reg <= 1'b0;
            bytes_left_reg <= '0;
        end
        else if (q_push)
        begin
            in_payload_reg <= in_payload_next;
            bytes_left_reg <= bytes_left_next;
        end
    end

    a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
        in_payload_reg |-> bytes_left_reg != '0)
        else $error("frame open with no bytes left");

    a_header_opens: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && q_entry.kind == KIND_HEADER && q_entry.payload_length != '0)
        |=> in_payload_reg)
        else $error("header with payload did not open a frame");

endmodule

// ===== hdl/ipv4fb_queue.sv =====
module ipv4fb_queue #(
    parameter int DEPTH = ipv4fb_pkg::FIFO_DEPTH_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  ipv4fb_pkg::entry_t     push_entry,
    input  logic                   pop,
    output ipv4fb_pkg::entry_t     pop_entry,
    output ipv4fb_pkg::q_status_t  status
);
    import ipv4fb_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    entry_t          mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;

    assign status.full  = (count_reg == CW'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_entry    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    // advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // store entries
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !status.full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("pop from empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count out of range");

endmodule

// ===== hdl/ipv4fb_back.sv =====
module ipv4fb_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ipv4fb_pkg::entry_t     q_entry,
    input  ipv4fb_pkg::q_status_t  q_status,
    output logic                   q_pop,
    input  ipv4fb_pkg::mac_cfg_t   mac_cfg,
    ipv4fb_result_if.source        result_out
);
    import ipv4fb_pkg::*;

    logic                  out_valid_reg;
    logic [BYTE_W-1:0]     out_byte_reg;
    logic                  out_end_reg;
    logic                  out_err_reg;

    logic                  busy_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [ADDR_W-1:0]     dst_reg;
    logic [ADDR_W-1:0]     src_reg;
    logic [BYTE_W-1:0]     proto_reg;
    logic [LEN_W-1:0]      len_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [SUM_W-1:0]      sum_next;

    logic                  advance;
    logic                  take;
    logic                  emit;
    logic [BYTE_W-1:0]     emit_byte;
    logic                  emit_end;
    logic                  emit_err;
    logic [BYTE_W-1:0]     hdr_byte;
    logic [TOTAL_W-1:0]    total_len;
    logic [15:0]           csum;

    assign advance = !out_valid_reg || result_out.ready;
    assign take    = advance && !busy_reg && !q_status.empty;
    assign q_pop   = take;
    assign emit    = busy_reg || take;

    assign total_len = TOTAL_W'(IP_HDR_BYTES) + TOTAL_W'(len_reg);
    assign csum      = ~sum_reg[15:0];

    // select header byte at the current position
    always_comb
    begin
        unique case (idx_reg)
            6'd1:    hdr_byte = mac_cfg.dest_mac[39:32];
            6'd2:    hdr_byte = mac_cfg.dest_mac[31:24];
            6'd3:    hdr_byte = mac_cfg.dest_mac[23:16];
            6'd4:    hdr_byte = mac_cfg.dest_mac[15:8];
            6'd5:    hdr_byte = mac_cfg.dest_mac[7:0];
            6'd6:    hdr_byte = mac_cfg.source_mac[47:40];
            6'd7:    hdr_byte = mac_cfg.source_mac[39:32];
            6'd8:    hdr_byte = mac_cfg.source_mac[31:24];
            6'd9:    hdr_byte = mac_cfg.source_mac[23:16];
            6'd10:   hdr_byte = mac_cfg.source_mac[15:8];
            6'd11:   hdr_byte = mac_cfg.source_mac[7:0];
            6'd12:   hdr_byte = ETHERTYPE_HI;
            6'd13:   hdr_byte = ETHERTYPE_LO;
            6'd14:   hdr_byte = VER_IHL;
            6'd15:   hdr_byte = 8'h00;
            6'd16:   hdr_byte = BYTE_W'(total_len[TOTAL_W-1:8]);
            6'd17:   hdr_byte = total_len[7:0];
            6'd18:   hdr_byte = IP_ID[15:8];
            6'd19:   hdr_byte = IP_ID[7:0];
            6'd20:   hdr_byte = FLAGS_DF;
            6'd21:   hdr_byte = 8'h00;
            6'd22:   hdr_byte = TTL_DEFAULT;
            6'd23:   hdr_byte = proto_reg;
            6'd24:   hdr_byte = csum[15:8];
            6'd25:   hdr_byte = csum[7:0];
            6'd26:   hdr_byte = src_reg[31:24];
            6'd27:   hdr_byte = src_reg[23:16];
            6'd28:   hdr_byte = src_reg[15:8];
            6'd29:   hdr_byte = src_reg[7:0];
            6'd30:   hdr_byte = dst_reg[31:24];
            6'd31:   hdr_byte = dst_reg[23:16];
            6'd32:   hdr_byte = dst_reg[15:8];
            6'd33:   hdr_byte = dst_reg[7:0];
            default: hdr_byte = '0;
        endcase
    end

    // accumulate the header checksum while the MAC bytes go out
    always_comb
    begin
        case (idx_reg)
            6'd1:    sum_next = SUM_W'(CSUM_BASE) + SUM_W'(total_len);
            6'd2:    sum_next = sum_reg + SUM_W'({TTL_DEFAULT, proto_reg});
            6'd3:    sum_next = sum_reg + SUM_W'(src_reg[31:16]);
            6'd4:    sum_next = sum_reg + SUM_W'(src_reg[15:0]);
            6'd5:    sum_next = sum_reg + SUM_W'(dst_reg[31:16]);
            6'd6:    sum_next = sum_reg + SUM_W'(dst_reg[15:0]);
            6'd7,
            6'd8:    sum_next = SUM_W'(sum_reg[15:0]) + SUM_W'(sum_reg[SUM_W-1:16]);
            default: sum_next = sum_reg;
        endcase
    end

    // pick the next result item
    always_comb
    begin
        emit_byte = '0;
        emit_end  = 1'b0;
        emit_err  = 1'b0;
        if (busy_reg)
        begin
            emit_byte = hdr_byte;
            emit_end  = (idx_reg == IDX_W'(HDR_BYTES - 1)) && (len_reg == '0);
        end
        else
        begin
            case (q_entry.kind)
                KIND_HEADER:  emit_byte = mac_cfg.dest_mac[MAC_W-1:MAC_W-8];
                KIND_PAYLOAD:
                begin
                    emit_byte = q_entry.data;
                    emit_end  = q_entry.last;
                end
                default:      emit_err  = 1'b1;
            endcase
        end
    end

    // control: header sequencer and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
        end
        else if (advance)
        begin
            out_valid_reg <= emit;
            if (busy_reg)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (idx_reg == IDX_W'(HDR_BYTES - 1))
                    busy_reg <= 1'b0;
            end
            else if (take && q_entry.kind == KIND_HEADER)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= IDX_W'(1);
            end
        end
    end

    // data: output byte, end and error flags, held header fields, checksum
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg <= emit_byte;
            out_end_reg  <= emit_end;
            out_err_reg  <= emit_err;
            if (busy_reg)
                sum_reg <= sum_next;
            else if (take)
            begin
                dst_reg   <= q_entry.dest_addr;
                src_reg   <= q_entry.source_addr;
                proto_reg <= q_entry.proto_number;
                len_reg   <= q_entry.payload_length;
            end
        end
    end

    assign result_out.valid      = out_valid_reg;
    assign result_out.frame_byte = out_byte_reg;
    assign result_out.frame_end  = out_end_reg;
    assign result_out.error      = out_err_reg;

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (idx_reg != '0) && (idx_reg <= IDX_W'(HDR_BYTES - 1)))
        else $error("header index out of range");

    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !q_pop)
        else $error("queue popped during header");

    a_err_no_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_err_reg) |-> !out_end_reg && out_byte_reg == '0)
        else $error("error item carries frame data");

endmodule

// ===== hdl/ipv4_ethernet_frame_builder_unit.sv =====
// IPv4-over-Ethernet frame builder.
// item_in: a start item (command 0) with IPv4 addresses, protocol and payload
//   length produces the 34-byte Ethernet + IPv4 header with its checksum; a
//   payload item (command 1) passes one byte. result_out carries one frame byte
//   per item, frame_end on the last byte, error on a rejected item (length over
//   the maximum, or payload byte with no open frame).
// cfg: index 0 writes the destination MAC, index 1 the source MAC; always ready.
//   Write only while the block is idle.
// Path: an item taken is written into the queue; the back pops it when it is
//   free and the output can advance, and registers its first result item.
// Throughput: one result byte per cycle from the back sequencer unless stalled;
//   a start item occupies it for its 34 header bytes, payload and error items
//   for one. The input is ready while the FIFO_DEPTH-entry queue between front
//   and back has room, so items keep entering during a header until it fills.
// Reset: MACs return to broadcast / 02:00:00:00:00:01, no frame is open, the
//   queue and the output register are empty.
// Stall: while result_out.ready is low the output register holds; the
//   sequencer freezes and the queue fills, then item_in.ready drops.
module ipv4_ethernet_frame_builder_unit #(
    parameter int FIFO_DEPTH = ipv4fb_pkg::FIFO_DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    ipv4fb_item_if.sink       item_in,
    ipv4fb_result_if.source   result_out,
    ipv4fb_cfg_if.sink        cfg
);
    import ipv4fb_pkg::*;

    mac_cfg_t  mac_cfg_reg;
    entry_t    push_entry;
    entry_t    pop_entry;
    q_status_t q_status;
    logic      q_push;
    logic      q_pop;

    assign cfg.ready = 1'b1;

    // hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mac_cfg_reg.dest_mac   <= DEST_MAC_RESET;
            mac_cfg_reg.source_mac <= SOURCE_MAC_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_DEST_MAC:   mac_cfg_reg.dest_mac   <= cfg.data;
                REG_SOURCE_MAC: mac_cfg_reg.source_mac <= cfg.data;
                default:        mac_cfg_reg            <= mac_cfg_reg;
            endcase
        end
    end

    ipv4fb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .item_in  (item_in),
        .q_status (q_status),
        .q_push   (q_push),
        .q_entry  (push_entry)
    );

    ipv4fb_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .pop_entry  (pop_entry),
        .status     (q_status)
    );

    ipv4fb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_entry    (pop_entry),
        .q_status   (q_status),
        .q_pop      (q_pop),
        .mac_cfg    (mac_cfg_reg),
        .result_out (result_out)
    );

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import ipv4fb_pkg::*;

    localparam int CYCLE_LIMIT = 500000;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              err;
    } frame_beat_t;

    typedef struct {
        logic              cmd;
        logic [ADDR_W-1:0] dst;
        logic [ADDR_W-1:0] src;
        logic [BYTE_W-1:0] proto;
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] pbyte;
        logic              typed;
        frame_beat_t       want;
    } stim_row_t;

    localparam frame_beat_t ERR_BEAT = '{8'h00, 1'b0, 1'b1};

    logic clk;
    logic rst_n;

    ipv4fb_item_if   item_ch ();
    ipv4fb_result_if res_ch ();
    ipv4fb_cfg_if    cfg_ch ();

    ipv4_ethernet_frame_builder_unit uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_ch),
        .result_out (res_ch),
        .cfg        (cfg_ch)
    );

    // frame builder state as the block should hold it
    logic [MAC_W-1:0] dest_mac_r;
    logic [MAC_W-1:0] src_mac_r;
    logic             frame_open;
    logic [LEN_W-1:0] bytes_owed;

    frame_beat_t pending_bytes[$];
    int          fails;
    int          cycles;
    bit          quiet;
    bit          gap_on;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // IPv4 header checksum over the ten big-endian words, checksum field zero
    function automatic logic [15:0] hdr_checksum(input logic [11:0] total,
                                                 input logic [7:0] proto,
                                                 input logic [31:0] src,
                                                 input logic [31:0] dst);
        logic [19:0] acc;
        acc = 20'h04500 + {8'h00, total} + 20'h00001 + 20'h04000 + {4'h0, 8'd64, proto}
            + {4'h0, src[31:16]} + {4'h0, src[15:0]}
            + {4'h0, dst[31:16]} + {4'h0, dst[15:0]};
        acc = {4'h0, acc[15:0]} + {16'h0000, acc[19:16]};
        acc = {4'h0, acc[15:0]} + {16'h0000, acc[19:16]};
        return ~acc[15:0];
    endfunction

    // work out the bytes that one accepted item produces and advance the state
    function automatic void build_frame_bytes(input stim_row_t r, ref frame_beat_t beats[$]);
        logic [7:0]  hdr [0:HDR_BYTES-1];
        logic [11:0] total;
        logic [15:0] csum;
        beats.delete();
        if (r.cmd == CMD_PAYLOAD)
        begin
            if (!frame_open)
            begin
                beats.push_back(ERR_BEAT);
                return;
            end
            bytes_owed = bytes_owed - 1'b1;
            frame_open = (bytes_owed != '0);
            beats.push_back('{r.pbyte, (bytes_owed == '0), 1'b0});
            return;
        end
        if (r.len > MAX_PAYLOAD)
        begin
            frame_open = 1'b0;
            bytes_owed = '0;
            beats.push_back(ERR_BEAT);
            return;
        end
        for (int i = 0; i < 6; i++)
        begin
            hdr[i]     = dest_mac_r[47-8*i -: 8];
            hdr[6 + i] = src_mac_r[47-8*i -: 8];
        end
        total   = 12'd20 + {1'b0, r.len};
        csum    = hdr_checksum(total, r.proto, r.src, r.dst);
        hdr[12] = 8'h08;
        hdr[13] = 8'h00;
        hdr[14] = 8'h45;
        hdr[15] = 8'h00;
        hdr[16] = {4'h0, total[11:8]};
        hdr[17] = total[7:0];
        hdr[18] = 8'h00;
        hdr[19] = 8'h01;
        hdr[20] = 8'h40;
        hdr[21] = 8'h00;
        hdr[22] = 8'd64;
        hdr[23] = r.proto;
        hdr[24] = csum[15:8];
        hdr[25] = csum[7:0];
        for (int i = 0; i < 4; i++)
        begin
            hdr[26 + i] = r.src[31-8*i -: 8];
            hdr[30 + i] = r.dst[31-8*i -: 8];
        end
        for (int i = 0; i < HDR_BYTES; i++)
            beats.push_back('{hdr[i], (i == HDR_BYTES - 1 && r.len == '0), 1'b0});
        frame_open = (r.len != '0);
        bytes_owed = r.len;
    endfunction

    function automatic stim_row_t stim_row(input logic cmd, input logic [31:0] dst,
                                           input logic [31:0] src, input logic [7:0] proto,
                                           input logic [10:0] len, input logic [7:0] pbyte,
                                           input logic typed, input frame_beat_t want);
        stim_row_t r;
        r.cmd   = cmd;
        r.dst   = dst;
        r.src   = src;
        r.proto = proto;
        r.len   = len;
        r.pbyte = pbyte;
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    function automatic stim_row_t rand_row(input logic cmd, input int len);
        return stim_row(cmd, $urandom, $urandom, 8'($urandom_range(0, 255)),
                        11'(len), 8'($urandom_range(0, 255)), 1'b0, '0);
    endfunction

    // present one item, hold it until taken, then queue what it should produce
    task automatic send_item(input stim_row_t r);
        frame_beat_t got[$];
        if (!quiet && gap_on && $urandom_range(0, 3) == 0)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        item_ch.valid          <= 1'b1;
        item_ch.command        <= r.cmd;
        item_ch.dest_addr      <= r.dst;
        item_ch.source_addr    <= r.src;
        item_ch.proto_number   <= r.proto;
        item_ch.payload_length <= r.len;
        item_ch.payload_byte   <= r.pbyte;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        build_frame_bytes(r, got);
        if (r.typed)
            pending_bytes.push_back(r.want);
        else
            foreach (got[i])
                pending_bytes.push_back(got[i]);
    endtask

    // hold off input until every expected byte has come out
    task automatic drain();
        item_ch.valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // caller lowers cfg valid once its writes are done
    task automatic write_mac(input logic idx, input logic [MAC_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        if (idx == REG_DEST_MAC)
            dest_mac_r = value;
        else
            src_mac_r = value;
    endtask

    // mostly whole frames, some cut short or overrun, some noise and oversize starts
    task automatic run_random(input int n);
        int left;
        int len;
        int body;
        int pick;
        left = n;
        while (left > 0)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
            begin
                len  = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 48)
                                                   : $urandom_range(0, 8);
                body = len;
                if ($urandom_range(0, 5) == 0)
                    body = $urandom_range(0, len);
                else if ($urandom_range(0, 7) == 0)
                    body = len + 1;
                send_item(rand_row(CMD_START, len));
                left--;
                repeat (body)
                begin
                    send_item(rand_row(CMD_PAYLOAD, $urandom_range(0, 2047)));
                    left--;
                end
            end
            else if (pick < 9)
            begin
                len = $urandom_range(0, 1) ? $urandom_range(0, 2047) : $urandom_range(0, 16);
                send_item(rand_row($urandom_range(0, 1) ? CMD_PAYLOAD : CMD_START, len));
                left--;
            end
            else
            begin
                send_item(rand_row(CMD_START, $urandom_range(MAX_PAYLOAD + 1, 2047)));
                left--;
            end
        end
    endtask

    // result side: ready in random stretches with stall bursts
    initial
    begin
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            res_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
            if (!quiet && $urandom_range(0, 1) == 1)
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
        end
    end

    // compare each taken byte with the oldest expectation
    always @(posedge clk)
    begin : result_check
        frame_beat_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_bytes.size() == 0)
            begin
                $error("unexpected result: frame_byte %h frame_end %b error %b",
                       res_ch.frame_byte, res_ch.frame_end, res_ch.error);
                fails++;
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (res_ch.frame_byte !== want.data)
                begin
                    $error("frame_byte: expected %h, actual %h", want.data, res_ch.frame_byte);
                    fails++;
                end
                if (res_ch.frame_end !== want.last)
                begin
                    $error("frame_end: expected %b, actual %b", want.last, res_ch.frame_end);
                    fails++;
                end
                if (res_ch.error !== want.err)
                begin
                    $error("error: expected %b, actual %b", want.err, res_ch.error);
                    fails++;
                end
            end
        end
    end

    // bound the run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin : stimulus
        stim_row_t        rows[$];
        logic [63:0]      wide_a;
        logic [63:0]      wide_b;
        logic [MAC_W-1:0] mac_d;
        logic [MAC_W-1:0] mac_s;
        fails                  = 0;
        cycles                 = 0;
        quiet                  = 1'b0;
        gap_on                 = 1'b1;
        dest_mac_r             = DEST_MAC_RESET;
        src_mac_r              = SOURCE_MAC_RESET;
        frame_open             = 1'b0;
        bytes_owed             = '0;
        rst_n                  = 1'b0;
        item_ch.valid          = 1'b0;
        item_ch.command        = CMD_START;
        item_ch.dest_addr      = '0;
        item_ch.source_addr    = '0;
        item_ch.proto_number   = '0;
        item_ch.payload_length = '0;
        item_ch.payload_byte   = '0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.index           = REG_DEST_MAC;
        cfg_ch.data            = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, MACs at their reset values
        rows.push_back(stim_row(CMD_PAYLOAD, 0, 0, 0, 0, 8'hFF, 1'b1, ERR_BEAT));
        rows.push_back(stim_row(CMD_START, 0, 0, 0, 0, 0, 1'b0, '0));
        rows.push_back(stim_row(CMD_PAYLOAD, 0, 0, 0, 0, 8'h00, 1'b1, ERR_BEAT));
        rows.push_back(stim_row(CMD_START, '1, '1, 8'hFF, 11'h7FF, 8'hFF, 1'b1, ERR_BEAT));
        rows.push_back(stim_row(CMD_START, 32'h0A000001, 32'h0A000002, 8'd17,
                                11'(MAX_PAYLOAD + 1), 0, 1'b1, ERR_BEAT));
        rows.push_back(stim_row(CMD_START, '1, '1, 8'hFF, 11'd1, 0, 1'b0, '0));
        rows.push_back(stim_row(CMD_PAYLOAD, 0, 0, 0, 0, 8'hFF, 1'b1,
                                '{8'hFF, 1'b1, 1'b0}));
        rows.push_back(stim_row(CMD_START, 32'hC0A80001, 32'h0A000001, 8'd17, 11'd3, 0,
                                1'b0, '0));
        rows.push_back(stim_row(CMD_PAYLOAD, 0, 0, 0, 0, 8'h00, 1'b0, '0));
        rows.push_back(stim_row(CMD_PAYLOAD, '1, '1, 8'hFF, 11'h7FF, 8'hA5, 1'b0, '0));
        // start while a frame is open: abandon it
        rows.push_back(stim_row(CMD_START, 32'h0A000002, 32'hC0A80001, 8'd6, 11'd2, 0,
                                1'b0, '0));
        rows.push_back(stim_row(CMD_PAYLOAD, 0, 0, 0, 0, 8'h5A, 1'b0, '0));
        rows.push_back(stim_row(CMD_PAYLOAD, 0, 0, 0, 0, 8'h3C, 1'b0, '0));
        rows.push_back(stim_row(CMD_START, 32'h7F000001, 32'h7F000001, 8'd1, 11'd4, 0,
                                1'b0, '0));
        rows.push_back(stim_row(CMD_PAYLOAD, 0, 0, 0, 0, 8'h81, 1'b0, '0));
        // oversize start drops the open frame
        rows.push_back(stim_row(CMD_START, 0, 0, 0, 11'(MAX_PAYLOAD + 1), 0, 1'b1,
                                ERR_BEAT));
        rows.push_back(stim_row(CMD_PAYLOAD, 0, 0, 0, 0, 8'h7E, 1'b1, ERR_BEAT));
        rows.push_back(stim_row(CMD_START, '1, '1, 8'hFF, 11'(MAX_PAYLOAD), 0, 1'b0, '0));
        rows.push_back(stim_row(CMD_PAYLOAD, 0, 0, 0, 0, 8'h11, 1'b0, '0));
        rows.push_back(stim_row(CMD_START, '1, 0, 0, 0, 0, 1'b0, '0));
        rows.push_back(stim_row(CMD_START, 0, '1, 8'hFF, 0, 0, 1'b0, '0));
        foreach (rows[i])
            send_item(rows[i]);
        drain();

        // random phases, each under its own MAC setting; the last runs without idling
        for (int p = 0; p < 5; p++)
        begin
            wide_a = {$urandom, $urandom};
            wide_b = {$urandom, $urandom};
            case (p)
                0: begin mac_d = '0;             mac_s = '0;           end
                1: begin mac_d = '1;             mac_s = '1;           end
                2: begin mac_d = wide_a[47:0];   mac_s = wide_b[47:0]; end
                3: begin mac_d = '0;             mac_s = '1;           end
                default: begin mac_d = DEST_MAC_RESET; mac_s = wide_b[47:0]; end
            endcase
            write_mac(REG_DEST_MAC, mac_d);
            write_mac(REG_SOURCE_MAC, mac_s);
            cfg_ch.valid <= 1'b0;
            quiet  = (p == 4);
            gap_on = (p == 0) || ($urandom_range(0, 1) == 1);
            run_random(45);
            drain();
        end

        repeat (20) @(posedge clk);
        if (fails == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/ipv4fb_pkg.sv
hdl/ipv4fb_if.sv
hdl/ipv4fb_front.sv
hdl/ipv4fb_queue.sv
hdl/ipv4fb_back.sv
hdl/ipv4_ethernet_frame_builder_unit.sv
bench/tb_top.sv
